### hw/rtl/cidtab_pkg.sv
// Shared types and constants for the client ID table with aging.
// Used by client_id_table_with_aging_core and its checker; no dependencies.
package cidtab_pkg;

   localparam int TableSize     = 256;
   localparam int IdxWidth      = $clog2(TableSize);
   localparam int KeyWidth      = 64;
   localparam int ClientIdWidth = 8;
   localparam int StatusWidth   = 2;
   localparam int RemovedWidth  = 9;

   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(TableSize - 1);

   // request commands
   localparam logic CmdSeek  = 1'b0;
   localparam logic CmdPurge = 1'b1;

   // response status codes
   localparam logic [StatusWidth-1:0] StatusFound    = 2'd0;
   localparam logic [StatusWidth-1:0] StatusAssigned = 2'd1;
   localparam logic [StatusWidth-1:0] StatusFull     = 2'd2;
   localparam logic [StatusWidth-1:0] StatusPurged   = 2'd3;

   typedef struct packed {
      logic                cmd;
      logic [KeyWidth-1:0] search_key;
   } req_type;

   typedef struct packed {
      logic [ClientIdWidth-1:0] client_id;
      logic [StatusWidth-1:0]   status;
      logic [RemovedWidth-1:0]  removed_count;
   } rsp_type;

   // wrapping index increment
   function automatic logic [IdxWidth-1:0] next_idx(input logic [IdxWidth-1:0] idx);
      logic [IdxWidth-1:0] res;
      if (idx == LastIdx) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

endpackage

### hw/rtl/client_id_table_with_aging_core.sv
// Client ID table with aging: 64-bit key to table-index ID, purge of stale IDs; uses cidtab_pkg.
// A seek compares the stored keys in index order and answers at the first hit; on a miss it
// claims the first free slot from the pointer on, or reports full; a purge sweeps every entry.
// One request at a time; busy drops in the cycle the response shows, so the
// next start may be taken then. The key store has one read port, scanned one entry per cycle.
// Synchronous reset clears valid and used bits and the pointer at once; no sweep.
module client_id_table_with_aging_core
   import cidtab_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;   // key compare sweep
   localparam logic [1:0] S_FREE  = 2'd2;   // free slot search from pointer
   localparam logic [1:0] S_PURGE = 2'd3;   // aging sweep

   logic [1:0]           state_ff, state_in;
   logic [TableSize-1:0] valid_ff, valid_in;
   logic [TableSize-1:0] used_ff, used_in;
   logic [IdxWidth-1:0]  next_free_ff, next_free_in;

   // sweep index: read address in match, slot in free search, entry in purge
   logic [IdxWidth-1:0]  scan_idx_ff, scan_idx_in;
   // free search: number of candidates already rejected
   logic [IdxWidth-1:0]  free_cnt_ff, free_cnt_in;
   // match pipeline: a read is outstanding for pend_idx
   logic                 pend_ff, pend_in;
   logic [IdxWidth-1:0]  pend_idx_ff, pend_idx_in;

   logic [KeyWidth-1:0]  key_ff, key_in;
   logic [RemovedWidth-1:0] removed_ff, removed_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // key store: one write, one registered read per cycle
   logic [KeyWidth-1:0]  key_mem [TableSize];
   logic [KeyWidth-1:0]  rd_data_ff;
   logic                 wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[scan_idx_ff] <= key_ff;
      end
      rd_data_ff <= key_mem[scan_idx_ff];
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      next_free_in  = next_free_ff;
      scan_idx_in   = scan_idx_ff;
      free_cnt_in   = free_cnt_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      key_in        = key_ff;
      removed_in    = removed_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in      = req_data.search_key;
               scan_idx_in = '0;
               pend_in     = 1'b0;
               removed_in  = '0;
               if (req_data.cmd == CmdPurge) begin
                  state_in = S_PURGE;
               end else begin
                  state_in = S_MATCH;
               end
            end
         end

         S_MATCH: begin
            // issue the read for scan_idx, compare the one read last cycle
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff;
            scan_idx_in = next_idx(scan_idx_ff);
            if (pend_ff) begin
               if (valid_ff[pend_idx_ff] && (rd_data_ff == key_ff)) begin
                  used_in[pend_idx_ff]      = 1'b1;
                  rsp_strobe_in             = 1'b1;
                  rsp_data_in.client_id     = ClientIdWidth'(pend_idx_ff);
                  rsp_data_in.status        = StatusFound;
                  rsp_data_in.removed_count = '0;
                  state_in                  = S_IDLE;
               end else if (pend_idx_ff == LastIdx) begin
                  // no hit: search free slots from the pointer
                  scan_idx_in = next_free_ff;
                  free_cnt_in = '0;
                  state_in    = S_FREE;
               end
            end
         end

         S_FREE: begin
            if (!valid_ff[scan_idx_ff]) begin
               wr_en                     = 1'b1;
               valid_in[scan_idx_ff]     = 1'b1;
               used_in[scan_idx_ff]      = 1'b1;
               next_free_in              = next_idx(scan_idx_ff);
               rsp_strobe_in             = 1'b1;
               rsp_data_in.client_id     = ClientIdWidth'(scan_idx_ff);
               rsp_data_in.status        = StatusAssigned;
               rsp_data_in.removed_count = '0;
               state_in                  = S_IDLE;
            end else if (free_cnt_ff == LastIdx) begin
               rsp_strobe_in             = 1'b1;
               rsp_data_in.client_id     = '0;
               rsp_data_in.status        = StatusFull;
               rsp_data_in.removed_count = '0;
               state_in                  = S_IDLE;
            end else begin
               scan_idx_in = next_idx(scan_idx_ff);
               free_cnt_in = free_cnt_ff + 1'b1;
            end
         end

         S_PURGE: begin
            if (valid_ff[scan_idx_ff] && !used_ff[scan_idx_ff]) begin
               valid_in[scan_idx_ff] = 1'b0;
               removed_in            = RemovedWidth'(removed_ff + 1'b1);
            end
            used_in[scan_idx_ff] = 1'b0;
            scan_idx_in          = next_idx(scan_idx_ff);
            if (scan_idx_ff == LastIdx) begin
               rsp_strobe_in             = 1'b1;
               rsp_data_in.client_id     = '0;
               rsp_data_in.status        = StatusPurged;
               rsp_data_in.removed_count = removed_in;
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         used_ff       <= '0;
         next_free_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         next_free_ff  <= next_free_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and sweep counters
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      free_cnt_ff <= free_cnt_in;
      pend_idx_ff <= pend_idx_in;
      key_ff      <= key_in;
      removed_ff  <= removed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### hw/rtl/cidtab_checker.sv
// Port-level checks for client_id_table_with_aging_core, bound into every instance of it.
// Depends on cidtab_pkg for types and status codes.
module cidtab_checker
   import cidtab_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // an accepted request holds the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // a response always ends a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("response without a request in flight");

   // responses never come back to back
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("responses in consecutive cycles");

   a_seek_no_removed: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != StatusPurged)) |-> (rsp_data.removed_count == '0))
      else $error("seek response with nonzero removed count");

   a_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_data.status == StatusPurged) || (rsp_data.status == StatusFull)))
         |-> (rsp_data.client_id == '0))
      else $error("purge or full response with nonzero client id");

endmodule

bind client_id_table_with_aging_core cidtab_checker u_cidtab_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### bench/client_id_table_with_aging_core_test.sv
// Self-checking bench for client_id_table_with_aging_core: directed and random
// seek and purge requests, with each response checked against a behavioral table.
// Depends on cidtab_pkg and client_id_table_with_aging_core.
module client_id_table_with_aging_core_test;
   import cidtab_pkg::*;

   // Behavioral copy of the ID table. Expected responses are computed when a
   // request is accepted and are queued in order, since the core answers one
   // request at a time.
   class cid_table_scoreboard;
      bit                  entry_valid [TableSize];
      logic [KeyWidth-1:0] entry_key   [TableSize];
      bit                  used_mark   [TableSize];
      int                  next_free_id;
      rsp_type             awaited_replies [$];
      int unsigned         failures;
      int unsigned         n_found, n_assigned, n_full, n_purges, n_dropped, n_checked;

      function rsp_type seek_reply(logic [KeyWidth-1:0] key);
         rsp_type r;
         int      slot;
         r = '0;
         // only valid slots are compared, so unwritten keys are never read
         for (int i = 0; i < TableSize; i++) begin
            if (entry_valid[i] && entry_key[i] == key) begin
               used_mark[i] = 1'b1;
               r.client_id = ClientIdWidth'(i);
               r.status = StatusFound;
               n_found++;
               return r;
            end
         end
         // miss: first free slot at or after the wrapping pointer
         for (int i = 0; i < TableSize; i++) begin
            slot = (next_free_id + i) % TableSize;
            if (!entry_valid[slot]) begin
               entry_valid[slot] = 1'b1;
               entry_key[slot] = key;
               used_mark[slot] = 1'b1;
               next_free_id = (slot + 1) % TableSize;
               r.client_id = ClientIdWidth'(slot);
               r.status = StatusAssigned;
               n_assigned++;
               return r;
            end
         end
         r.status = StatusFull;
         n_full++;
         return r;
      endfunction

      function rsp_type purge_reply();
         rsp_type r;
         int      dropped;
         r = '0;
         dropped = 0;
         for (int i = 0; i < TableSize; i++) begin
            if (entry_valid[i] && !used_mark[i]) begin
               entry_valid[i] = 1'b0;
               dropped++;
            end
            used_mark[i] = 1'b0;
         end
         r.status = StatusPurged;
         r.removed_count = RemovedWidth'(dropped);
         n_purges++;
         n_dropped += dropped;
         return r;
      endfunction

      function void note_request(req_type req);
         if (req.cmd == CmdPurge) begin
            awaited_replies.push_back(purge_reply());
         end else begin
            awaited_replies.push_back(seek_reply(req.search_key));
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_replies.size() == 0) begin
            $error("response with no request outstanding: id %0d status %0d removed %0d",
                   got.client_id, got.status, got.removed_count);
            failures++;
            return;
         end
         want = awaited_replies.pop_front();
         n_checked++;
         if (got.client_id !== want.client_id) begin
            $error("client_id: expected %0d, got %0d", want.client_id, got.client_id);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, got %0d",
                   want.removed_count, got.removed_count);
            failures++;
         end
      endfunction
   endclass

   // Key mixes for the random part: a flood of fresh keys fills the table and
   // keeps it full, a hot set mostly hits, a wide set mixes hits and misses.
   typedef enum int {KeysFresh, KeysHot, KeysWide} key_mix_type;

   localparam int RandomItems = 1130;
   localparam int DrainCycles = 520;   // worst single-request latency plus margin

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   cid_table_scoreboard sb;

   client_id_table_with_aging_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [KeyWidth-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Present a request and hold it until the core takes it. Called at a rising
   // edge; returns at the edge where start was high and busy low. start is
   // raised once here, so back-to-back requests keep it high without a glitch.
   task automatic send_request(input logic cmd, input logic [KeyWidth-1:0] key);
      req_type req;
      req.cmd = cmd;
      req.search_key = key;
      start <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      sb.note_request(req);
   endtask

   // Random gap before the next request; the request lines carry junk meanwhile,
   // which the core must ignore while start is low.
   task automatic idle_for_a_while(input int pct);
      req_type junk;
      if ($urandom_range(99) < pct) begin
         junk.cmd = 1'($urandom);
         junk.search_key = random_key();
         start <= 1'b0;
         req_data <= junk;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // Responses cannot be held off: every strobe is checked at the edge ending it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_response(rsp_data);
      end
   end

   initial begin
      logic [KeyWidth-1:0] pool [$];
      key_mix_type         mix;
      int                  seg_left;
      int                  purge_odds;
      int                  pct;
      int                  sent;

      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: purge of an empty table, extreme keys, hits after misses,
      // purges that keep fresh entries and then drop the ones not seen again,
      // and a claim that must follow the pointer rather than the lowest free ID.
      send_request(CmdPurge, '0);
      send_request(CmdSeek, '0);                     // zero key on a cleared table
      send_request(CmdSeek, '1);
      send_request(CmdSeek, '0);                     // hit on ID 0
      send_request(CmdSeek, 64'h8000_0000_0000_0000);
      send_request(CmdSeek, 64'h0000_0000_0000_0001);
      send_request(CmdPurge, '1);                    // key ignored; all fresh, none dropped
      send_request(CmdSeek, '1);
      send_request(CmdSeek, 64'h0000_0000_0000_0001);
      send_request(CmdPurge, 64'h5555_5555_5555_5555);  // drops the two not reused
      send_request(CmdSeek, '0);                     // pointer is past 0, so a new ID
      send_request(CmdPurge, '0);
      send_request(CmdPurge, '0);
      send_request(CmdPurge, '0);                    // empty again
      send_request(CmdSeek, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CmdSeek, 64'h5555_5555_5555_5555);

      // Random: the first segment floods fresh keys with no purge, so the table
      // fills, the pointer wraps and full is reported; later segments pick a
      // key mix at random. Sender idles 25%, then 59%, then not at all.
      sent = 0;
      mix = KeysFresh;
      seg_left = 300;
      purge_odds = 0;
      while (sent < RandomItems) begin
         if (seg_left == 0) begin
            mix = key_mix_type'($urandom_range(2));
            seg_left = $urandom_range(50, 200);
            pool.delete();
            case (mix)
               KeysFresh: begin
                  purge_odds = 150;
               end
               KeysHot: begin
                  purge_odds = 25;
                  repeat (48) pool.push_back(random_key());
               end
               default: begin
                  purge_odds = 50;
                  repeat (300) pool.push_back(random_key());
               end
            endcase
         end
         if (sent < RandomItems / 3) begin
            pct = 25;
         end else if (sent < 2 * RandomItems / 3) begin
            pct = 59;
         end else begin
            pct = 0;
         end
         idle_for_a_while(pct);
         if (purge_odds != 0 && $urandom_range(purge_odds - 1) == 0) begin
            send_request(CmdPurge, random_key());
         end else if (mix == KeysFresh) begin
            send_request(CmdSeek, random_key());
         end else begin
            send_request(CmdSeek, pool[$urandom_range(pool.size() - 1)]);
         end
         sent++;
         seg_left--;
      end
      start <= 1'b0;

      // Drain, then give the core time to show any stray response.
      while (sb.awaited_replies.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d requests: %0d hits, %0d new IDs, %0d table-full seeks,",
               sb.n_found + sb.n_assigned + sb.n_full + sb.n_purges,
               sb.n_found, sb.n_assigned, sb.n_full);
      $display("  %0d purges dropping %0d entries; %0d responses checked.",
               sb.n_purges, sb.n_dropped, sb.n_checked);
      if (sb.failures == 0 && sb.awaited_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: well beyond every request taking the full-table latency plus gaps.
   initial begin
      #50_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
